>>> hw/rtl/kss_pkg.sv
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types, constants and the base code table of the k-mer seed encoder.
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned KLEN_W      = 5;
  localparam int unsigned NLIM_W      = 16;
  localparam int unsigned WIN_W       = 32;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned BUCKET_W    = 8;
  localparam int unsigned SUFFIX_W    = 24;
  localparam int unsigned BLKPOS_W    = 22;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned POS_SHIFT    = 10;
  localparam int unsigned PREFIX_BASES = 4;
  localparam int unsigned MAX_BASES    = 16;

  localparam logic [KLEN_W-1:0] KLEN_MIN = KLEN_W'(PREFIX_BASES + 1);
  localparam logic [KLEN_W-1:0] KLEN_MAX = KLEN_W'(MAX_BASES);

  localparam logic [CHAR_W-1:0] CHAR_N = 8'h4e;

  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_N_LIMIT  = 1'b1;

  localparam logic [KLEN_W-1:0] KMER_LEN_RST = 5'd12;
  localparam logic [NLIM_W-1:0] N_LIMIT_RST  = 16'd10;

  typedef struct packed {
    logic [KLEN_W-1:0] kmer_len;
    logic [NLIM_W-1:0] n_limit;
  } cfg_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [SUFFIX_W-1:0] kmer_suffix;
    logic [BLKPOS_W-1:0] block_pos;
  } res_t;

  function automatic logic [CODE_W-1:0] base_code(input logic [CHAR_W-1:0] c);
    logic [CODE_W-1:0] code;
    case (c)
      8'h41, 8'h61: code = 3'd0;
      8'h43, 8'h63: code = 3'd1;
      8'h47, 8'h67: code = 3'd2;
      8'h4e, 8'h6e: code = 3'd2;
      8'h54, 8'h74: code = 3'd3;
      default:      code = 3'd4;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/kss_in_if.sv
// ----------------------------------------------------------------------------
// kss_in_if
// Character stream channel: one genome byte and an end-of-sequence mark.
// ----------------------------------------------------------------------------
interface kss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       end_of_sequence;

  modport source (output valid, output base_char, output end_of_sequence, input ready);
  modport sink   (input valid, input base_char, input end_of_sequence, output ready);
endinterface

>>> hw/rtl/kss_out_if.sv
// ----------------------------------------------------------------------------
// kss_out_if
// Seed channel: bucket, suffix and block position of one window.
// ----------------------------------------------------------------------------
interface kss_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bucket;
  logic [23:0] kmer_suffix;
  logic [21:0] block_pos;

  modport source (output valid, output bucket, output kmer_suffix, output block_pos,
                  input ready);
  modport sink   (input valid, input bucket, input kmer_suffix, input block_pos,
                  output ready);
endinterface

>>> hw/rtl/kss_core.sv
// ----------------------------------------------------------------------------
// kss_core
// Rolling window state and per-character update: fill, stream and N skip.
// ----------------------------------------------------------------------------
module kss_core
  import kss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              fire,
  input  logic [CHAR_W-1:0] base_char,
  input  logic              end_of_sequence,
  output logic              emit,
  output res_t              res
);

  typedef enum logic [1:0] {
    MODE_FILL   = 2'd0,
    MODE_STREAM = 2'd1,
    MODE_SKIP   = 2'd2
  } mode_t;

  mode_t             mode, mode_next;
  logic [WIN_W-1:0]  window_code, window_code_next;
  logic [NLIM_W-1:0] n_run, n_run_next;
  logic [KLEN_W-1:0] fill_count, fill_count_next;
  logic [POS_W-1:0]  char_position;
  logic [POS_W-1:0]  window_start, window_start_next;

  logic [KLEN_W-1:0] k;
  logic [5:0]        win_bits;
  logic [5:0]        sfx_bits;
  logic [WIN_W-1:0]  wmask;
  logic [WIN_W-1:0]  smask;
  logic [WIN_W-1:0]  shifted;
  logic [NLIM_W-1:0] run_inc;
  logic              is_n;

  always_comb begin
    if (cfg.kmer_len < KLEN_MIN) begin
      k = KLEN_MIN;
    end else if (cfg.kmer_len > KLEN_MAX) begin
      k = KLEN_MAX;
    end else begin
      k = cfg.kmer_len;
    end
  end

  assign win_bits = {k, 1'b0};
  assign sfx_bits = {k - KLEN_W'(PREFIX_BASES), 1'b0};
  assign wmask    = ~({WIN_W{1'b1}} << win_bits);
  assign smask    = ~({WIN_W{1'b1}} << sfx_bits);
  assign shifted  = ((window_code << 2) & wmask) | WIN_W'(base_code(base_char));
  assign is_n     = (base_char == CHAR_N);
  assign run_inc  = (n_run != {NLIM_W{1'b1}}) ? n_run + NLIM_W'(1) : n_run;

  always_comb begin
    mode_next         = mode;
    window_code_next  = window_code;
    n_run_next        = n_run;
    fill_count_next   = fill_count;
    window_start_next = window_start;
    emit              = 1'b0;

    if (mode == MODE_SKIP && !is_n) begin
      mode_next       = MODE_FILL;
      fill_count_next = '0;
      n_run_next      = '0;
    end

    case (mode_next)
      MODE_STREAM: begin
        if (is_n && (run_inc > cfg.n_limit)) begin
          mode_next  = MODE_SKIP;
          n_run_next = '0;
        end else begin
          n_run_next        = is_n ? run_inc : '0;
          window_code_next  = shifted;
          window_start_next = char_position - POS_W'(k) + POS_W'(1);
          emit              = 1'b1;
        end
      end
      MODE_SKIP: begin
      end
      default: begin
        if (fill_count_next == '0) begin
          window_start_next = char_position;
          n_run_next        = '0;
        end
        window_code_next = shifted;
        fill_count_next  = fill_count_next + KLEN_W'(1);
        if (fill_count_next >= k) begin
          emit            = 1'b1;
          mode_next       = MODE_STREAM;
          fill_count_next = '0;
        end
      end
    endcase
  end

  assign res.bucket      = BUCKET_W'(window_code_next >> sfx_bits);
  assign res.kmer_suffix = SUFFIX_W'(window_code_next & smask);
  assign res.block_pos   = BLKPOS_W'(window_start_next >> POS_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_FILL;
      window_code   <= '0;
      n_run         <= '0;
      fill_count    <= '0;
      char_position <= '0;
      window_start  <= '0;
    end else if (fire) begin
      if (end_of_sequence) begin
        mode          <= MODE_FILL;
        window_code   <= '0;
        n_run         <= '0;
        fill_count    <= '0;
        char_position <= '0;
        window_start  <= '0;
      end else begin
        mode          <= mode_next;
        window_code   <= window_code_next;
        n_run         <= n_run_next;
        fill_count    <= fill_count_next;
        char_position <= char_position + POS_W'(1);
        window_start  <= window_start_next;
      end
    end
  end

endmodule

>>> hw/rtl/kss_out_buf.sv
// ----------------------------------------------------------------------------
// kss_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module kss_out_buf
  import kss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  res_t      push_data,
  output logic      full,
  kss_out_if.source seed_out
);

  res_t head, tail;
  logic head_valid, tail_valid;
  logic pop;

  assign pop  = head_valid && seed_out.ready;
  assign full = tail_valid;

  assign seed_out.valid       = head_valid;
  assign seed_out.bucket      = head.bucket;
  assign seed_out.kmer_suffix = head.kmer_suffix;
  assign seed_out.block_pos   = head.block_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (pop) begin
      if (tail_valid) begin
        head       <= tail;
        tail_valid <= push;
        if (push) begin
          tail <= push_data;
        end
      end else begin
        head_valid <= push;
        if (push) begin
          head <= push_data;
        end
      end
    end else if (!head_valid) begin
      head_valid <= push;
      if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      tail       <= push_data;
      tail_valid <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/kmer_seed_stream_encoder.sv
// A completed window's seed goes to the output register, or to the skid register
// while one waits. Throughput: one character per cycle unless the buffer is full;
// the window update is a single registered pass, and a two-entry output buffer
// keeps input open while one seed waits. Reset (rst, synchronous) clears the
// window, counters and buffer and sets kmer_len to 12 and n_limit to 10.
// ----------------------------------------------------------------------------
// kmer_seed_stream_encoder
// Rolling 2-bit k-mer seed encoder with N-run skipping and config registers.
// ----------------------------------------------------------------------------
module kmer_seed_stream_encoder
  import kss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  kss_in_if.sink                char_in,
  kss_out_if.source             seed_out
);

  cfg_t cfg;
  logic fire;
  logic emit;
  logic buf_full;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kmer_len <= KMER_LEN_RST;
      cfg.n_limit  <= N_LIMIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_KMER_LEN: cfg.kmer_len <= wr_data[KLEN_W-1:0];
        CFG_N_LIMIT:  cfg.n_limit  <= wr_data[NLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign char_in.ready = !buf_full;
  assign fire          = char_in.valid && !buf_full;

  kss_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .fire            (fire),
    .base_char       (char_in.base_char),
    .end_of_sequence (char_in.end_of_sequence),
    .emit            (emit),
    .res             (res)
  );

  kss_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && emit),
    .push_data (res),
    .full      (buf_full),
    .seed_out  (seed_out)
  );

endmodule

>>> hw/rtl/kss_checker.sv
// ----------------------------------------------------------------------------
// kss_checker
// Port-level checks of the seed encoder, bound to the top level.
// ----------------------------------------------------------------------------
module kss_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  bucket,
  input logic [23:0] kmer_suffix,
  input logic [21:0] block_pos
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("seed output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bucket) && $stable(kmer_suffix)
      && $stable(block_pos))
    else $error("stalled seed changed or vanished");

  a_in_open: assert property (@(posedge clk) disable iff (rst)
    $past(out_ready) |-> in_ready)
    else $error("input closed although the output side drained");

  a_seed_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("seed appeared without a character transfer");

endmodule

bind kmer_seed_stream_encoder kss_checker u_kss_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (char_in.valid),
  .in_ready    (char_in.ready),
  .out_valid   (seed_out.valid),
  .out_ready   (seed_out.ready),
  .bucket      (seed_out.bucket),
  .kmer_suffix (seed_out.kmer_suffix),
  .block_pos   (seed_out.block_pos)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the k-mer seed encoder. Genome bytes stream in with
// random gaps while seeds drain with random stalls and one long hold-off. An
// in-bench copy of the encoder predicts every seed, and the seed checker
// compares each transferred seed field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import kss_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned STALL_CYCLES   = 80;

  localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
  localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
  localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

  typedef enum logic [1:0] {
    MODE_FILL   = 2'd0,
    MODE_STREAM = 2'd1,
    MODE_SKIP   = 2'd2
  } enc_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;

  kss_in_if  char_ch ();
  kss_out_if seed_ch ();

  kmer_seed_stream_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .char_in  (char_ch),
    .seed_out (seed_ch)
  );

  always #4 clk = ~clk;

  // Encoder copy
  logic [KLEN_W-1:0] cfg_klen;
  logic [NLIM_W-1:0] cfg_nlim;
  logic [WIN_W-1:0]  enc_win;
  logic [NLIM_W-1:0] enc_nrun;
  enc_mode_t         enc_mode;
  logic [KLEN_W-1:0] enc_fill;
  logic [POS_W-1:0]  enc_pos;
  logic [POS_W-1:0]  enc_start;

  res_t pending_seeds[$];
  res_t want_seed;
  int   errors = 0;
  bit   no_idle = 1'b0;
  bit   stall_go = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  logic [CHAR_W-1:0] nucs [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

  function automatic void clear_encoder();
    enc_win   = '0;
    enc_nrun  = '0;
    enc_mode  = MODE_FILL;
    enc_fill  = '0;
    enc_pos   = '0;
    enc_start = '0;
  endfunction

  function automatic void shift_window(input logic [CODE_W-1:0] code, input int kk);
    logic [WIN_W-1:0] wmask;
    wmask   = 32'hffff_ffff >> (32 - 2 * kk);
    enc_win = ((enc_win << 2) & wmask) | WIN_W'(code);
  endfunction

  function automatic void push_seed(input int kk);
    int               sh;
    logic [WIN_W-1:0] smask;
    res_t             s;
    sh            = 2 * (kk - int'(PREFIX_BASES));
    smask         = 32'hffff_ffff >> (32 - sh);
    s.bucket      = BUCKET_W'((enc_win >> sh) & 32'hff);
    s.kmer_suffix = SUFFIX_W'(enc_win & smask);
    s.block_pos   = BLKPOS_W'(enc_start >> POS_SHIFT);
    pending_seeds.push_back(s);
  endfunction

  function automatic void step_encoder(input logic [CHAR_W-1:0] c, input logic eos);
    logic [KLEN_W-1:0] k;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  pos;
    logic              drop;
    if (cfg_klen < KLEN_MIN) k = KLEN_MIN;
    else if (cfg_klen > KLEN_MAX) k = KLEN_MAX;
    else k = cfg_klen;
    case (c)
      "A", "a": code = CODE_A;
      "C", "c": code = CODE_C;
      "G", "g": code = CODE_G;
      "N", "n": code = CODE_G;
      "T", "t": code = CODE_T;
      default:  code = CODE_OTHER;
    endcase
    pos = enc_pos;
    if (enc_mode == MODE_SKIP && c != CHAR_N) begin
      enc_mode = MODE_FILL;
      enc_fill = '0;
      enc_nrun = '0;
    end
    if (enc_mode == MODE_STREAM) begin
      drop = 1'b0;
      if (c == CHAR_N) begin
        if (enc_nrun != 16'hffff) enc_nrun = enc_nrun + 1'b1;
        if (enc_nrun > cfg_nlim) begin
          enc_mode = MODE_SKIP;
          enc_nrun = '0;
          drop     = 1'b1;
        end
      end else begin
        enc_nrun = '0;
      end
      if (!drop) begin
        shift_window(code, int'(k));
        enc_start = pos - POS_W'(k) + 1'b1;
        push_seed(int'(k));
      end
    end else if (enc_mode != MODE_SKIP) begin
      if (enc_fill == '0) begin
        enc_start = pos;
        enc_nrun  = '0;
      end
      shift_window(code, int'(k));
      enc_fill = enc_fill + 1'b1;
      if (enc_fill >= k) begin
        push_seed(int'(k));
        enc_mode = MODE_STREAM;
        enc_fill = '0;
      end
    end
    enc_pos = pos + 1'b1;
    if (eos) clear_encoder();
  endfunction

  // Seed receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      seed_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (stall_go) begin
      seed_ch.ready <= 1'b0;
      stall_left = STALL_CYCLES - 1;
      stall_go   = 1'b0;
    end else begin
      seed_ch.ready <= no_idle || ($urandom_range(99) >= 19);
    end
  end

  // Seed checker
  always @(posedge clk) begin
    if (!rst && seed_ch.valid && seed_ch.ready) begin
      if (pending_seeds.size() == 0) begin
        errors++;
        $display("%0t: unexpected seed: expected none, actual %h/%h/%h", $time,
                 seed_ch.bucket, seed_ch.kmer_suffix, seed_ch.block_pos);
      end else begin
        want_seed = pending_seeds.pop_front();
        if (seed_ch.bucket !== want_seed.bucket) begin
          errors++;
          $display("%0t: bucket mismatch: expected %h, actual %h", $time,
                   want_seed.bucket, seed_ch.bucket);
        end
        if (seed_ch.kmer_suffix !== want_seed.kmer_suffix) begin
          errors++;
          $display("%0t: kmer_suffix mismatch: expected %h, actual %h", $time,
                   want_seed.kmer_suffix, seed_ch.kmer_suffix);
        end
        if (seed_ch.block_pos !== want_seed.block_pos) begin
          errors++;
          $display("%0t: block_pos mismatch: expected %h, actual %h", $time,
                   want_seed.block_pos, seed_ch.block_pos);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (char_ch.valid && char_ch.ready) || (seed_ch.valid && seed_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic eos);
    while (!no_idle && $urandom_range(99) < 19) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid           <= 1'b1;
    char_ch.base_char       <= c;
    char_ch.end_of_sequence <= eos;
    do @(posedge clk); while (!char_ch.ready);
    step_encoder(c, eos);
  endtask

  task automatic drain(input int settle);
    char_ch.valid <= 1'b0;
    while (pending_seeds.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain(4);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    if (idx == CFG_KMER_LEN) cfg_klen = data[KLEN_W-1:0];
    else cfg_nlim = data[NLIM_W-1:0];
  endtask

  // Mostly bases and N runs, some lowercase n and raw bytes; skipped N not counted
  task automatic send_random(input int count, input int burst_max, input bit allow_eos);
    int                n_left;
    int                sent;
    int                r;
    logic [CHAR_W-1:0] c;
    n_left = 0;
    sent   = 0;
    while (sent < count) begin
      if (n_left > 0) begin
        c = CHAR_N;
        n_left--;
      end else begin
        r = $urandom_range(99);
        if (r < 52) c = nucs[$urandom_range(7)];
        else if (r < 62) begin
          c      = CHAR_N;
          n_left = $urandom_range(burst_max);
        end else if (r < 72) c = "n";
        else if (r < 80) c = CHAR_N;
        else c = CHAR_W'($urandom_range(255));
      end
      if (!(enc_mode == MODE_SKIP && c == CHAR_N)) sent++;
      send_char(c, allow_eos && ($urandom_range(49) == 0));
    end
  endtask

  task automatic test_reset_settings();
    string s;
    s = "ACGTNacgtnTG";
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic test_fill_and_skip();
    write_reg(CFG_KMER_LEN, 16'hffe5);
    write_reg(CFG_N_LIMIT, 16'd1);
    send_char("A", 1'b0);
    send_char("C", 1'b0);
    send_char("G", 1'b0);
    send_char("T", 1'b0);
    send_char(8'hff, 1'b0);
    send_char(CHAR_N, 1'b0);
    // widen mid-stream: start position goes below zero
    write_reg(CFG_KMER_LEN, 16'd31);
    send_char(8'h00, 1'b0);
    send_char(CHAR_N, 1'b0);
    send_char(CHAR_N, 1'b0);
    send_char(CHAR_N, 1'b0);
    send_char("C", 1'b1);
  endtask

  task automatic test_length_change();
    send_char("A", 1'b0);
    send_char("C", 1'b0);
    send_char("G", 1'b0);
    send_char("T", 1'b0);
    send_char("A", 1'b0);
    // shrink mid-fill below range, and drop the first N of a stream run
    write_reg(CFG_KMER_LEN, 16'd0);
    write_reg(CFG_N_LIMIT, 16'd0);
    send_char(CHAR_N, 1'b0);
    send_char(CHAR_N, 1'b1);
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] klen;
    logic [CFG_DATA_W-1:0] nlim;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin klen = 16'd5;  nlim = 16'd0;     end
        1: begin klen = 16'd16; nlim = 16'hffff;  end
        2: begin klen = 16'd12; nlim = 16'd10;    end
        3: begin klen = 16'd0;  nlim = 16'd3;     end
        4: begin klen = 16'd31; nlim = 16'd1;     end
        default: begin
          klen = CFG_DATA_W'($urandom);
          nlim = CFG_DATA_W'($urandom_range(20));
        end
      endcase
      write_reg(CFG_KMER_LEN, klen);
      write_reg(CFG_N_LIMIT, nlim);
      no_idle = (p == 3);
      send_random(70, (nlim > 24 ? 24 : int'(nlim)) + 4, 1'b1);
      no_idle = 1'b0;
    end
  endtask

  task automatic test_output_backpressure();
    write_reg(CFG_KMER_LEN, 16'd6);
    write_reg(CFG_N_LIMIT, 16'd8);
    stall_go = 1'b1;
    send_random(60, 10, 1'b0);
  endtask

  task automatic test_block_position();
    write_reg(CFG_KMER_LEN, 16'd7);
    write_reg(CFG_N_LIMIT, 16'd16);
    send_random(120, 20, 1'b0);
  endtask

  initial begin
    char_ch.valid           = 1'b0;
    char_ch.base_char       = '0;
    char_ch.end_of_sequence = 1'b0;
    seed_ch.ready           = 1'b0;
    cfg_klen = KMER_LEN_RST;
    cfg_nlim = N_LIMIT_RST;
    clear_encoder();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_settings();
    test_fill_and_skip();
    test_length_change();
    test_random_settings();
    test_output_backpressure();
    test_block_position();

    drain(10);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
